// ----- rtl/core/tti_pkg.sv -----
// Shared types, codes and helper functions of the thermistor table interpolator.
`timescale 1ns / 1ps
package tti_pkg;

  localparam int TTI_DEPTH = 64;      // default table depth
  localparam int TTI_ENTRY_W = 26;    // raw (12) over temperature (14)
  localparam int TTI_NW = 30;         // divider numerator width
  localparam int TTI_DW = 16;         // divider denominator width

  // floor(n / 125) = (n * TTI_RECIP_125) >> TTI_RECIP_SH for every n below 2^21
  localparam logic [21:0] TTI_RECIP_125 = 22'd2147484;
  localparam int TTI_RECIP_SH = 28;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_CONV = 2'd1,
    CMD_SETP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_CONV    = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_LOADED  = 2'd2
  } stat_t;

  localparam logic [2:0] MODE_NTC = 3'd0;
  localparam logic [2:0] MODE_PTC = 3'd1;
  localparam logic [2:0] MODE_AMP5 = 3'd2;
  localparam logic [2:0] MODE_AMP10 = 3'd3;
  localparam logic [2:0] MODE_DIG = 3'd4;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_REDUCE = 2'd2;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_WALK,
    SQ_DIV,
    SQ_DONE
  } seq_t;

  function automatic logic signed [14:0] sat_q4(input logic signed [31:0] v);
    if (v > 32'sd16383) return 15'sd16383;
    else if (v < -32'sd16384) return -15'sd16384;
    else return v[14:0];
  endfunction

  function automatic logic [11:0] sat_raw(input logic signed [31:0] v);
    if (v > 32'sd4095) return 12'd4095;
    else if (v < 32'sd0) return 12'd0;
    else return v[11:0];
  endfunction

endpackage

// ----- rtl/core/thermistor_table_interpolator_unit.sv -----
// Top level of the thermistor table interpolator: table store, walk sequencer, result registers.
`timescale 1ns / 1ps
// Converts between raw sensor readings and temperatures through a loaded table of
// (raw, temperature) pairs, or through fixed scales for amplifier and digital sensors.
// Each input transaction yields exactly one result transaction carrying the stored raw
// reading, temperature (Q.4 degrees), setpoint and a status code. A table conversion
// walks the table one entry per cycle through the registered read port of the table
// RAM, then passes through the bit-serial divider when an interpolation is needed.
// Scale conversions, amplifier setpoints included, need no walk and no division: the
// amplifier setpoint drops the power-of-two part of the scale and divides the rest by
// 125 through a reciprocal multiplication. The user must see that configuration is
// written only while idle; the block itself does not enforce it. The table holds no
// reset value: entries read before being loaded give undefined results.
module thermistor_table_interpolator_unit
  import tti_pkg::*;
#(
  parameter int TABLE_DEPTH = TTI_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [5:0]         entry_index,
  input  logic [11:0]        entry_raw,
  input  logic signed [13:0] entry_temp,
  input  logic [11:0]        sample,
  input  logic signed [13:0] target_temp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        raw_reading,
  output logic signed [14:0] temperature_q4,
  output logic [11:0]        setpoint_raw,
  output logic [1:0]         status
);
  localparam int IW = $clog2(TABLE_DEPTH);

  // configuration
  logic [2:0] sensor_mode;
  logic [6:0] entry_count;
  logic [1:0] reduce_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_mode <= 3'd5;
      entry_count <= 7'd2;
      reduce_bits <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   sensor_mode <= cfg_data[2:0];
        REG_COUNT:  entry_count <= cfg_data;
        REG_REDUCE: reduce_bits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // derived settings
  logic [1:0]  red;
  logic [11:0] full;
  logic [3:0]  scale_sh;
  logic        known;
  logic [IW-1:0] n_last;
  int          n_int;

  assign red = (reduce_bits == 2'd3) ? 2'd2 : reduce_bits;
  assign full = 12'd1023 << (2'd2 - red);
  assign scale_sh = 4'd12 - 4'(red);
  assign known = sensor_mode <= MODE_DIG;

  always_comb begin
    n_int = int'(entry_count);
    if (n_int < 2) n_int = 2;
    if (n_int > TABLE_DEPTH) n_int = TABLE_DEPTH;
  end
  assign n_last = IW'(n_int - 1);

  // state
  seq_t seq, seq_next;
  cmd_t cmd_in, cmd_q;
  logic [11:0] x_q;
  logic signed [13:0] tgt_q;
  logic [IW-1:0] k;
  logic [11:0] r0;
  logic signed [13:0] t0;
  logic signed [15:0] base_q;
  logic [1:0] stat_q;
  logic [11:0] last_raw;
  logic signed [14:0] last_temperature;
  logic [11:0] last_setpoint;

  logic accept;
  assign cmd_in = cmd_t'(command);
  assign accept = in_valid && in_ready;

  // table RAM
  logic ram_we;
  logic [IW-1:0] ram_raddr;
  logic [TTI_ENTRY_W-1:0] ram_rdata;

  tti_ram #(.WIDTH(TTI_ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(IW'(entry_index)),
    .wdata({entry_raw, entry_temp}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // current entry and interpolation terms
  logic [11:0] cur_raw;
  logic signed [13:0] cur_temp;
  logic fwd, ntc, hit;
  logic signed [12:0] dx, dr, dr_inv;
  logic signed [14:0] dt, dtt, dd;
  logic signed [27:0] p_fwd, p_inv;
  logic signed [TTI_NW-1:0] walk_num;
  logic signed [TTI_DW-1:0] walk_den;
  logic signed [15:0] walk_base, end_base;

  assign cur_raw = ram_rdata[25:14];
  assign cur_temp = ram_rdata[13:0];
  assign fwd = cmd_q == CMD_CONV;
  assign ntc = sensor_mode == MODE_NTC;
  assign hit = fwd ? (cur_raw > x_q) : (ntc ? (cur_temp < tgt_q) : (cur_temp > tgt_q));

  assign dx = $signed({1'b0, x_q}) - $signed({1'b0, r0});
  assign dr = $signed({1'b0, cur_raw}) - $signed({1'b0, r0});
  assign dt = 15'(cur_temp) - 15'(t0);
  assign dtt = 15'(t0) - 15'(tgt_q);
  assign dr_inv = $signed({1'b0, r0}) - $signed({1'b0, cur_raw});
  assign dd = 15'(t0) - 15'(cur_temp);
  assign p_fwd = 28'(dx) * 28'(dt);
  assign p_inv = 28'(dtt) * 28'(dr_inv);
  assign walk_num = fwd ? TTI_NW'(p_fwd) <<< 1 : TTI_NW'(p_inv);
  assign walk_den = fwd ? TTI_DW'(dr) : TTI_DW'(dd);

  // base value from the held pair, and from the current one when the walk runs out
  assign walk_base = fwd ? 16'(t0) <<< 1 :
                     (ntc ? $signed({4'd0, full}) - $signed({4'd0, r0})
                          : $signed({4'd0, r0}));
  assign end_base = fwd ? 16'(cur_temp) <<< 1 :
                    (ntc ? $signed({4'd0, full}) - $signed({4'd0, cur_raw})
                         : $signed({4'd0, cur_raw}));

  // direct conversions at acceptance
  logic [11:0] x_in;
  logic signed [13:0] ntc_raw;
  logic [25:0] amp_p;
  logic signed [13:0] dig_sp;
  logic [2:0]  amp_sh;
  logic [20:0] amp_n;
  logic [42:0] amp_prod;
  logic [14:0] amp_q;
  logic [11:0] amp_sp;

  assign x_in = sample >> red;
  assign ntc_raw = $signed({2'b0, full}) - $signed({2'b0, x_in});
  assign amp_p = 26'(x_in) * ((sensor_mode == MODE_AMP5) ? 26'd16000 : 26'd8000);
  assign dig_sp = (target_temp + $signed({13'd0, target_temp[13]})) >>> 1;

  // amplifier setpoint: T * 2^(12-R) / (2^6 * 125) or / (2^5 * 125); a negative
  // target truncates to zero or below and so saturates to 0
  assign amp_sh = ((sensor_mode == MODE_AMP5) ? 3'd6 : 3'd7) - 3'(red);
  assign amp_n = 21'(target_temp[12:0]) << amp_sh;
  assign amp_prod = 43'(amp_n) * 43'(TTI_RECIP_125);
  assign amp_q = amp_prod[TTI_RECIP_SH +: 15];
  assign amp_sp = target_temp[13] ? 12'd0 :
                  ((amp_q > 15'd4095) ? 12'd4095 : amp_q[11:0]);

  // divider
  logic div_start, div_done;
  logic signed [TTI_NW-1:0] div_num, div_quo;
  logic signed [TTI_DW-1:0] div_den;

  tti_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quo(div_quo)
  );

  // next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE: begin
        if (in_valid) begin
          seq_next = SQ_DONE;
          if (known && (sensor_mode <= MODE_PTC) &&
              (cmd_in == CMD_CONV || cmd_in == CMD_SETP)) seq_next = SQ_WALK;
        end
      end
      SQ_WALK: begin
        if (k != '0) begin
          if (hit) seq_next = (walk_den == '0) ? SQ_DONE : SQ_DIV;
          else if (k == n_last) seq_next = SQ_DONE;
        end
      end
      SQ_DIV: if (div_done) seq_next = SQ_DONE;
      SQ_DONE: if (!out_valid || out_ready) seq_next = SQ_IDLE;
      default: seq_next = SQ_IDLE;
    endcase
  end

  // control outputs
  logic commit;
  logic signed [31:0] commit_val;

  always_comb begin
    in_ready = 1'b0;
    ram_we = 1'b0;
    ram_raddr = '0;
    div_start = 1'b0;
    div_num = walk_num;
    div_den = walk_den;
    commit = 1'b0;
    commit_val = 32'(walk_base);
    unique case (seq)
      SQ_IDLE: begin
        in_ready = 1'b1;
        ram_we = in_valid && cmd_in == CMD_LOAD && (int'(entry_index) < TABLE_DEPTH);
      end
      SQ_WALK: begin
        ram_raddr = IW'(k + 1'b1);
        if (k != '0) begin
          if (hit) begin
            div_start = walk_den != '0;
            commit = walk_den == '0;
          end else if (k == n_last) begin
            commit = 1'b1;
            commit_val = 32'(end_base);
          end
        end
      end
      SQ_DIV: begin
        commit = div_done;
        commit_val = 32'(base_q) + 32'(div_quo);
      end
      SQ_DONE: ;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      out_valid <= 1'b0;
      last_raw <= '0;
      last_temperature <= '0;
      last_setpoint <= '0;
    end else begin
      seq <= seq_next;

      if (accept) begin
        cmd_q <= cmd_in;
        x_q <= x_in;
        tgt_q <= target_temp;
        k <= '0;
        base_q <= '0;
        priority case (cmd_in)
          CMD_LOAD: stat_q <= STAT_LOADED;
          CMD_CONV: begin
            if (!known) begin
              last_raw <= 12'd4095;
              stat_q <= STAT_UNKNOWN;
            end else begin
              stat_q <= STAT_CONV;
              unique case (sensor_mode)
                MODE_NTC: last_raw <= ntc_raw[13] ? 12'd0 : ntc_raw[11:0];
                MODE_PTC: last_raw <= x_in;
                MODE_AMP5, MODE_AMP10: begin
                  last_raw <= x_in;
                  last_temperature <= $signed(15'(amp_p >> scale_sh));
                end
                default: begin
                  last_raw <= sample;
                  last_temperature <= $signed({1'b0, sample, 2'b00});
                end
              endcase
            end
          end
          CMD_SETP: begin
            if (!known) begin
              stat_q <= STAT_UNKNOWN;
            end else begin
              stat_q <= STAT_CONV;
              if (sensor_mode == MODE_DIG) last_setpoint <= sat_raw(32'(dig_sp));
              else if (sensor_mode == MODE_AMP5 || sensor_mode == MODE_AMP10)
                last_setpoint <= amp_sp;
            end
          end
          default: stat_q <= STAT_CONV;
        endcase
      end

      if (seq == SQ_WALK) begin
        k <= k + 1'b1;
        if (k == '0 || !hit) begin
          r0 <= cur_raw;
          t0 <= cur_temp;
        end else begin
          base_q <= walk_base;
        end
      end

      if (commit) begin
        if (fwd) last_temperature <= sat_q4(commit_val);
        else last_setpoint <= sat_raw(commit_val);
      end

      if (seq == SQ_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        raw_reading <= last_raw;
        temperature_q4 <= last_temperature;
        setpoint_raw <= last_setpoint;
        status <= stat_q;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ram_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> accept) else $error("table written outside an accepted load");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> seq == SQ_DIV) else $error("quotient arrived outside divide phase");
  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_DONE && !out_valid) |=> out_valid) else $error("result not presented");
endmodule

// ----- rtl/core/tti_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/tti_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module tti_div
  import tti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [TTI_NW-1:0] num,
  input  logic signed [TTI_DW-1:0] den,
  output logic                     done,
  output logic signed [TTI_NW-1:0] quo
);
  localparam int CW = $clog2(TTI_NW + 1);

  logic [TTI_NW-1:0] acc;
  logic [TTI_DW-1:0] dmag;
  logic [TTI_DW:0]   rem;
  logic              neg;
  logic              busy;
  logic [CW-1:0]     cnt;
  logic [TTI_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem[TTI_DW-1:0], acc[TTI_NW-1]};
  assign fits = rem_sh >= {1'b0, dmag};
  assign quo = neg ? -$signed(acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(TTI_NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= num[TTI_NW-1] ? TTI_NW'(-num) : num;
        dmag <= den[TTI_DW-1] ? TTI_DW'(-den) : den;
        rem <= '0;
        neg <= num[TTI_NW-1] ^ den[TTI_DW-1];
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dmag} : rem_sh;
        acc <= {acc[TTI_NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(TTI_NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider failed to start");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider still busy at done");
endmodule

// ----- tb/sv/tb_thermistor_table_interpolator_unit.sv -----
// Self-checking testbench of the thermistor table interpolator: predictor, driver, checker.
`timescale 1ns / 1ps

// One request transaction as presented on the input channel.
typedef struct packed {
  tti_pkg::cmd_t      cmd;
  logic [5:0]         idx;
  logic [11:0]        eraw;
  logic signed [13:0] etemp;
  logic [11:0]        smp;
  logic signed [13:0] tgt;
} tti_request_t;

// One reading transaction as returned on the output channel.
typedef struct packed {
  logic [11:0]        raw;
  logic signed [14:0] q4;
  logic [11:0]        sp;
  logic [1:0]         st;
} tti_reading_t;

// Mirror of the block's table and registers; queues the readings it should return.
class reading_ledger;
  logic [11:0]        pair_raw[64];
  logic signed [13:0] pair_temp[64];
  logic [11:0]        held_raw;
  logic signed [14:0] held_q4;
  logic [11:0]        held_sp;
  logic [2:0]         mode;
  logic [6:0]         count;
  logic [1:0]         reduce;
  tti_reading_t       due[$];
  int                 mismatches;

  function new();
    held_raw = '0;
    held_q4 = '0;
    held_sp = '0;
    mode = 3'd5;
    count = 7'd2;
    reduce = 2'd0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [6:0] val);
    case (idx)
      tti_pkg::REG_MODE: mode = val[2:0];
      tti_pkg::REG_COUNT: count = val;
      tti_pkg::REG_REDUCE: reduce = val[1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due.size();
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int pairs_in_use();
    return int'(clamp(longint'(count), 2, 64));
  endfunction

  // Raw to temperature: first entry whose raw exceeds x, else the last one.
  function longint raw_to_q4(longint x);
    longint r0, t0, rk, tk;
    r0 = longint'(pair_raw[0]);
    t0 = longint'(pair_temp[0]);
    for (int k = 1; k < pairs_in_use(); k++) begin
      rk = longint'(pair_raw[k]);
      tk = longint'(pair_temp[k]);
      if (rk > x) begin
        if (rk == r0) return 2 * t0;
        return 2 * t0 + (2 * (x - r0) * (tk - t0)) / (rk - r0);
      end
      r0 = rk;
      t0 = tk;
    end
    return 2 * t0;
  endfunction

  // Temperature to raw setpoint by the inverse walk.
  function longint temp_to_raw(longint t, bit ntc, longint full);
    longint r0, t0, rk, tk, term;
    r0 = longint'(pair_raw[0]);
    t0 = longint'(pair_temp[0]);
    for (int k = 1; k < pairs_in_use(); k++) begin
      rk = longint'(pair_raw[k]);
      tk = longint'(pair_temp[k]);
      if (ntc ? (tk < t) : (tk > t)) begin
        term = (t0 != tk) ? ((t0 - t) * (r0 - rk)) / (t0 - tk) : 0;
        return ntc ? full - r0 + term : r0 + term;
      end
      r0 = rk;
      t0 = tk;
    end
    return ntc ? full - r0 : r0;
  endfunction

  function tti_reading_t predict_reading(tti_request_t rq);
    longint x, full, scale, q4, sp, tgt;
    int r;
    bit known;
    tti_reading_t res;
    r = reduce > 2 ? 2 : int'(reduce);
    full = 1023 << (2 - r);
    scale = 1024 << (2 - r);
    x = longint'(rq.smp) >> r;
    tgt = longint'(rq.tgt);
    known = mode <= 3'd4;
    res.st = tti_pkg::STAT_CONV;
    case (rq.cmd)
      tti_pkg::CMD_LOAD: begin
        pair_raw[rq.idx] = rq.eraw;
        pair_temp[rq.idx] = rq.etemp;
        res.st = tti_pkg::STAT_LOADED;
      end
      tti_pkg::CMD_CONV: begin
        if (!known) begin
          held_raw = 12'd4095;
          res.st = tti_pkg::STAT_UNKNOWN;
        end else begin
          case (mode)
            tti_pkg::MODE_NTC: begin
              held_raw = 12'(clamp(full - x, 0, 4095));
              q4 = raw_to_q4(x);
            end
            tti_pkg::MODE_PTC: begin
              held_raw = 12'(x);
              q4 = raw_to_q4(x);
            end
            tti_pkg::MODE_AMP5: begin
              held_raw = 12'(x);
              q4 = (x * 16000) / scale;
            end
            tti_pkg::MODE_AMP10: begin
              held_raw = 12'(x);
              q4 = (x * 8000) / scale;
            end
            default: begin
              held_raw = rq.smp;
              q4 = longint'(rq.smp) * 4;
            end
          endcase
          held_q4 = 15'(clamp(q4, -16384, 16383));
        end
      end
      tti_pkg::CMD_SETP: begin
        if (!known) begin
          res.st = tti_pkg::STAT_UNKNOWN;
        end else begin
          case (mode)
            tti_pkg::MODE_NTC: sp = temp_to_raw(tgt, 1'b1, full);
            tti_pkg::MODE_PTC: sp = temp_to_raw(tgt, 1'b0, full);
            tti_pkg::MODE_AMP5: sp = (tgt * scale) / 8000;
            tti_pkg::MODE_AMP10: sp = (tgt * scale) / 4000;
            default: sp = tgt / 2;
          endcase
          held_sp = 12'(clamp(sp, 0, 4095));
        end
      end
      default: ;
    endcase
    res.raw = held_raw;
    res.q4 = held_q4;
    res.sp = held_sp;
    return res;
  endfunction

  function void log_request(tti_request_t rq);
    due.push_back(predict_reading(rq));
  endfunction

  task flag(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  task check_reading(tti_reading_t got);
    tti_reading_t want;
    if (due.size() == 0) begin
      flag("unexpected reading, raw", got.raw, -1);
      return;
    end
    want = due.pop_front();
    if (got.raw !== want.raw) flag("raw_reading", got.raw, want.raw);
    if (got.q4 !== want.q4) flag("temperature_q4", got.q4, want.q4);
    if (got.sp !== want.sp) flag("setpoint_raw", got.sp, want.sp);
    if (got.st !== want.st) flag("status", got.st, want.st);
  endtask
endclass

module tb_thermistor_table_interpolator_unit;
  import tti_pkg::*;

  localparam int STALL_LIMIT = 5000;  // cycles with no transaction before giving up
  localparam int SETTLE = 150;        // covers the slowest walk plus division

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         command;
  logic [5:0]         entry_index;
  logic [11:0]        entry_raw;
  logic signed [13:0] entry_temp;
  logic [11:0]        sample;
  logic signed [13:0] target_temp;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        raw_reading;
  logic signed [14:0] temperature_q4;
  logic [11:0]        setpoint_raw;
  logic [1:0]         status;

  reading_ledger ledger;
  int sent;             // transactions accepted on the input side
  int send_gap_pct;     // chance per cycle that the sender idles
  int recv_gap_pct;     // chance per cycle that the receiver stalls
  bit hold_request;     // asks the receiver for a long stall
  int quiet_cycles;

  thermistor_table_interpolator_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold counted here when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Check the returned reading before logging a new request taken at the same edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_reading('{raw_reading, temperature_q4, setpoint_raw, status});
    if (!rst && in_valid && in_ready)
      ledger.log_request('{cmd_t'(command), entry_index, entry_raw, entry_temp, sample,
                           target_temp});
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL thermistor_table_interpolator_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until taken. Called just after a falling edge.
  task automatic send(cmd_t cmd, logic [5:0] idx, logic [11:0] eraw, logic signed [13:0] etemp,
                      logic [11:0] smp, logic signed [13:0] tgt);
    // idle pattern follows progress: receiver-heavy gaps, then sender-heavy, then none
    if (sent < 520) begin
      send_gap_pct = 35;
      recv_gap_pct = 75;
    end else if (sent < 1040) begin
      send_gap_pct = 75;
      recv_gap_pct = 35;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= cmd;
    entry_index <= idx;
    entry_raw <= eraw;
    entry_temp <= etemp;
    sample <= smp;
    target_temp <= tgt;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every reading is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [2:0] mode, logic [6:0] count, logic [1:0] reduce);
    drain();
    write_reg(REG_MODE, 7'(mode));
    write_reg(REG_COUNT, count);
    write_reg(REG_REDUCE, 7'(reduce));
  endtask

  // Load all 64 pairs: ascending raw, temperature falling for NTC and rising for PTC.
  // Small steps of zero make equal neighbours in both columns.
  task automatic load_table(bit ntc);
    int r, t, step, tstep;
    r = $urandom_range(40);
    t = ntc ? $urandom_range(8191, 4000) : -int'($urandom_range(8192, 4000));
    for (int k = 0; k < 64; k++) begin
      send(CMD_LOAD, 6'(k), 12'(r), 14'(t), 12'($urandom), 14'($urandom));
      step = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 128));
      r = (r + step > 4095) ? 4095 : r + step;
      tstep = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(300));
      t = ntc ? ((t - tstep < -8192) ? -8192 : t - tstep)
              : ((t + tstep > 8191) ? 8191 : t + tstep);
    end
  endtask

  // Random traffic: mostly conversions and setpoints, some stray loads and unused commands.
  task automatic traffic(int n, bit pressure);
    int pick, tsel;
    logic signed [13:0] tgt;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 3) hold_request = 1'b1;
      if (pressure && i == 2 * n / 3) drain();
      pick = $urandom_range(99);
      tsel = $urandom_range(63);
      // half the targets sit near a table temperature so the inverse walk interpolates
      tgt = ($urandom_range(1)) ? 14'($urandom) :
            14'(ledger.pair_temp[tsel] + $signed(14'($urandom_range(40))) - 14'sd20);
      if (pick < 45)
        send(CMD_CONV, 6'($urandom), 12'($urandom), 14'($urandom), 12'($urandom), tgt);
      else if (pick < 90)
        send(CMD_SETP, 6'($urandom), 12'($urandom), 14'($urandom), 12'($urandom), tgt);
      else if (pick < 95)
        send(CMD_LOAD, 6'($urandom), 12'($urandom), 14'($urandom), 12'($urandom), tgt);
      else
        send(CMD_NONE, 6'($urandom), 12'($urandom), 14'($urandom), 12'($urandom), tgt);
    end
  endtask

  initial begin
    ledger = new();
    sent = 0;
    send_gap_pct = 35;
    recv_gap_pct = 75;
    hold_request = 1'b0;
    quiet_cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_NONE;
    entry_index = '0;
    entry_raw = '0;
    entry_temp = '0;
    sample = '0;
    target_temp = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: unknown mode out of reset, the unused command, digital and amplifier extremes, unknown code 7.
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd4095, 14'sd0);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, -14'sd8192);
    send(CMD_NONE, 6'd63, 12'd4095, 14'sd8191, 12'd4095, 14'sd8191);
    configure(MODE_DIG, 7'd2, 2'd0);
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd0);
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd4095, 14'sd0);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd8191);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, -14'sd8192);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, -14'sd1);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd1);
    configure(MODE_AMP5, 7'd2, 2'd0);
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd4095, 14'sd0);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd8191);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, -14'sd8192);
    configure(MODE_AMP10, 7'd2, 2'd3);
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd4095, 14'sd0);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd8191);
    configure(3'd7, 7'd2, 2'd0);
    send(CMD_CONV, 6'd0, 12'd0, 14'sd0, 12'd100, 14'sd0);
    send(CMD_SETP, 6'd0, 12'd0, 14'sd0, 12'd0, 14'sd100);

    // Table phases: fill every entry before any walk can read it.
    configure(MODE_NTC, 7'd64, 2'd0);
    load_table(1'b1);
    traffic(300, 1'b1);
    configure(MODE_PTC, 7'd2, 2'd2);
    load_table(1'b0);
    traffic(150, 1'b0);
    configure(MODE_PTC, 7'd40, 2'd1);
    traffic(150, 1'b0);
    configure(MODE_NTC, 7'd127, 2'd3);
    load_table(1'b1);
    traffic(260, 1'b0);
    configure(MODE_NTC, 7'd0, 2'd1);
    traffic(100, 1'b0);

    // Scale modes and the remaining unknown codes.
    configure(MODE_AMP5, 7'd64, 2'd1);
    traffic(100, 1'b0);
    configure(MODE_AMP10, 7'd64, 2'd0);
    traffic(100, 1'b0);
    configure(MODE_DIG, 7'd64, 2'd2);
    traffic(100, 1'b0);
    configure(3'd5, 7'd64, 2'd0);
    traffic(40, 1'b0);
    configure(3'd6, 7'd64, 2'd0);
    traffic(40, 1'b0);

    drain();
    if (ledger.mismatches == 0) begin
      $display("PASS thermistor_table_interpolator_unit");
    end else begin
      $display("FAIL thermistor_table_interpolator_unit");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/tti_pkg.sv
rtl/core/tti_ram.sv
rtl/core/tti_div.sv
rtl/core/thermistor_table_interpolator_unit.sv
tb/sv/tb_thermistor_table_interpolator_unit.sv
